FILE: sv/tsls_pkg.sv
// Shared constants, control-word types and microcode table of the tour swap local search.
package tsls_pkg;

    // Sizing of the stores
    localparam int MAX_CITIES = 128;
    localparam int DIST_BITS  = 24;
    localparam int SLOT_W     = $clog2(MAX_CITIES);
    localparam int CNT_W      = $clog2(MAX_CITIES + 1);
    localparam int DADDR_W    = $clog2(MAX_CITIES * MAX_CITIES);

    // Fixed field widths
    localparam int REQ_W     = 2;
    localparam int CITY_W    = 7;
    localparam int POS_W     = 7;
    localparam int DIN_W     = 24;
    localparam int LEN_W     = 32;
    localparam int STALL_W   = 16;
    localparam int CC_W      = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DW    = 16;

    // Reset values of the registers
    localparam logic [CC_W-1:0]    CITY_COUNT_RST  = 8'd128;
    localparam logic [STALL_W-1:0] STALL_LIMIT_RST = 16'd100;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CITY_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_LIMIT = 1'b1;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_LOAD_DIST = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_TOUR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_EVAL      = 2'd2;
    localparam logic [REQ_W-1:0] REQ_SWAP      = 2'd3;

    // Program steps
    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] STEP_FETCH     = 5'd0;
    localparam logic [PC_W-1:0] STEP_DECODE    = 5'd1;
    localparam logic [PC_W-1:0] STEP_LOAD_DIST = 5'd2;
    localparam logic [PC_W-1:0] STEP_LOAD_TOUR = 5'd3;
    localparam logic [PC_W-1:0] STEP_SWAP_CHK  = 5'd4;
    localparam logic [PC_W-1:0] STEP_BAD       = 5'd5;
    localparam logic [PC_W-1:0] STEP_SCOUT_CHK = 5'd6;
    localparam logic [PC_W-1:0] STEP_SUM_START = 5'd7;
    localparam logic [PC_W-1:0] STEP_SUM_FIRST = 5'd8;
    localparam logic [PC_W-1:0] STEP_LOOP_RD   = 5'd9;
    localparam logic [PC_W-1:0] STEP_LOOP_LINK = 5'd10;
    localparam logic [PC_W-1:0] STEP_CLOSE     = 5'd11;
    localparam logic [PC_W-1:0] STEP_DRAIN     = 5'd12;
    localparam logic [PC_W-1:0] STEP_COMMIT    = 5'd13;
    localparam logic [PC_W-1:0] STEP_EVAL_CMT  = 5'd14;
    localparam logic [PC_W-1:0] STEP_SWAP_CMP  = 5'd15;
    localparam logic [PC_W-1:0] STEP_STALL     = 5'd16;
    localparam logic [PC_W-1:0] STEP_WR_A      = 5'd17;
    localparam logic [PC_W-1:0] STEP_WR_B      = 5'd18;
    localparam logic [PC_W-1:0] STEP_DONE      = 5'd19;

    // Branch conditions of a control word
    typedef enum logic [3:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_WAIT_IN,
        COND_DISPATCH,
        COND_NOT_BAD,
        COND_SCOUT,
        COND_MORE,
        COND_TRIAL,
        COND_BETTER,
        COND_WAIT_OUT
    } cond_t;

    // One control word
    typedef struct packed {
        cond_t           cond;
        logic [PC_W-1:0] target;
        logic            in_ready;
        logic            wr_dist;
        logic            wr_tour;
        logic            set_bad;
        logic            sum_start;
        logic            first;
        logic            tour_rd;
        logic            link;
        logic            close;
        logic            eval_cmt;
        logic            stall_upd;
        logic            wr_a;
        logic            wr_b;
        logic            out_ld;
    } ucw_t;

    // Microcode table
    function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
        ucw_t w;
        w = '0;
        w.cond   = COND_ALWAYS;
        w.target = STEP_FETCH;
        case (pc)
            STEP_FETCH: begin
                w.in_ready = 1'b1;
                w.cond     = COND_WAIT_IN;
                w.target   = STEP_DECODE;
            end
            STEP_DECODE: begin
                w.cond = COND_DISPATCH;
            end
            STEP_LOAD_DIST: begin
                w.wr_dist = 1'b1;
                w.target  = STEP_DONE;
            end
            STEP_LOAD_TOUR: begin
                w.wr_tour = 1'b1;
                w.target  = STEP_DONE;
            end
            STEP_SWAP_CHK: begin
                w.cond   = COND_NOT_BAD;
                w.target = STEP_SCOUT_CHK;
            end
            STEP_BAD: begin
                w.set_bad = 1'b1;
                w.target  = STEP_DONE;
            end
            STEP_SCOUT_CHK: begin
                w.cond   = COND_SCOUT;
                w.target = STEP_DONE;
            end
            STEP_SUM_START: begin
                w.sum_start = 1'b1;
                w.cond      = COND_NEXT;
            end
            STEP_SUM_FIRST: begin
                w.first = 1'b1;
                w.cond  = COND_NEXT;
            end
            STEP_LOOP_RD: begin
                w.tour_rd = 1'b1;
                w.cond    = COND_NEXT;
            end
            STEP_LOOP_LINK: begin
                w.link   = 1'b1;
                w.cond   = COND_MORE;
                w.target = STEP_LOOP_RD;
            end
            STEP_CLOSE: begin
                w.close = 1'b1;
                w.cond  = COND_NEXT;
            end
            STEP_DRAIN: begin
                w.cond = COND_NEXT;
            end
            STEP_COMMIT: begin
                w.cond   = COND_TRIAL;
                w.target = STEP_SWAP_CMP;
            end
            STEP_EVAL_CMT: begin
                w.eval_cmt = 1'b1;
                w.target   = STEP_DONE;
            end
            STEP_SWAP_CMP: begin
                w.cond   = COND_BETTER;
                w.target = STEP_WR_A;
            end
            STEP_STALL: begin
                w.stall_upd = 1'b1;
                w.target    = STEP_DONE;
            end
            STEP_WR_A: begin
                w.wr_a = 1'b1;
                w.cond = COND_NEXT;
            end
            STEP_WR_B: begin
                w.wr_b = 1'b1;
                w.cond = COND_NEXT;
            end
            STEP_DONE: begin
                w.out_ld = 1'b1;
                w.cond   = COND_WAIT_OUT;
                w.target = STEP_FETCH;
            end
            default: begin
                w.target = STEP_FETCH;
            end
        endcase
        return w;
    endfunction

    // First step of each request
    function automatic logic [PC_W-1:0] dispatch(input logic [REQ_W-1:0] req);
        logic [PC_W-1:0] s;
        case (req)
            REQ_LOAD_DIST: s = STEP_LOAD_DIST;
            REQ_LOAD_TOUR: s = STEP_LOAD_TOUR;
            REQ_EVAL:      s = STEP_SUM_START;
            REQ_SWAP:      s = STEP_SWAP_CHK;
            default:       s = STEP_FETCH;
        endcase
        return s;
    endfunction

endpackage

FILE: sv/tour_swap_local_search.sv
// Top level: microcoded sequencer, tour and distance stores, tour length datapath.
// Flow: a load writes its store and goes to the result step; an evaluate or a swap walks
// the tour in two steps per slot (read, link) over the n active slots (n = active city count),
// then closes the loop; a swap with a bad position or while scout skips the walk.
// Throughput: one transaction at a time; the next is accepted in the cycle after the result
// is loaded into the output register, which holds it until taken.
// Reset (aresetn low, synchronous): tour is identity order through per-slot valid bits,
// length all ones, stall count and scout cleared, city_count 128, stall_limit 100.
module tour_swap_local_search (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [tsls_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [tsls_pkg::CFG_DW-1:0]         cfg_wdata,
    // request channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [tsls_pkg::REQ_W-1:0]          s_req_type,
    input  logic [tsls_pkg::CITY_W-1:0]         s_from_city,
    input  logic [tsls_pkg::CITY_W-1:0]         s_to_city,
    input  logic [tsls_pkg::DIN_W-1:0]          s_distance_value,
    input  logic [tsls_pkg::POS_W-1:0]          s_position,
    input  logic [tsls_pkg::CITY_W-1:0]         s_city_id,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tsls_pkg::LEN_W-1:0]          m_tour_length,
    output logic                                m_accepted,
    output logic [tsls_pkg::STALL_W-1:0]        m_stall_count,
    output logic                                m_scout,
    output logic                                m_bad_request
);

    localparam int SLOT_W  = tsls_pkg::SLOT_W;
    localparam int CNT_W   = tsls_pkg::CNT_W;
    localparam int DADDR_W = tsls_pkg::DADDR_W;
    localparam int CITY_W  = tsls_pkg::CITY_W;
    localparam int LEN_W   = tsls_pkg::LEN_W;
    localparam int STALL_W = tsls_pkg::STALL_W;
    localparam int DBITS   = tsls_pkg::DIST_BITS;
    localparam int MAXC    = tsls_pkg::MAX_CITIES;

    // Sequencer
    logic [tsls_pkg::PC_W-1:0] pc_reg, pc_next;
    tsls_pkg::ucw_t            uc;

    // Configuration
    logic [tsls_pkg::CC_W-1:0] cfg_cc_reg;
    logic [STALL_W-1:0]        cfg_limit_reg;

    // Latched request
    logic [tsls_pkg::REQ_W-1:0] req_reg;
    logic [CITY_W-1:0]          from_reg, to_reg, cid_reg;
    logic [tsls_pkg::DIN_W-1:0] dval_reg;
    logic [tsls_pkg::POS_W-1:0] pos_reg;

    // Architectural state
    logic [LEN_W-1:0]   cur_len_reg, cur_len_next;
    logic [STALL_W-1:0] stall_reg, stall_next;
    logic               scout_reg, scout_next;
    logic               acc_reg, acc_next;
    logic               bad_reg, bad_next;

    // Tour walk datapath
    logic [LEN_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CITY_W-1:0]  prev_reg, prev_next;
    logic [CITY_W-1:0]  first_reg, first_next;
    logic [CITY_W-1:0]  swap_a_reg, swap_a_next;
    logic [CITY_W-1:0]  swap_b_reg, swap_b_next;

    // Stores
    logic [CITY_W-1:0]  tour_mem [MAXC];
    logic [MAXC-1:0]    tour_vld_reg;
    logic [CITY_W-1:0]  tour_q_reg;
    logic               tour_qv_reg;
    logic [SLOT_W-1:0]  tour_qa_reg;
    logic [DBITS-1:0]   dist_mem [MAXC*MAXC];
    logic [DBITS-1:0]   dist_q_reg;
    logic               dv_reg;
    logic               doob_reg;

    // Output register
    logic               m_valid_reg;
    logic [LEN_W-1:0]   m_len_reg;
    logic               m_acc_reg;
    logic [STALL_W-1:0] m_stall_reg;
    logic               m_scout_reg;
    logic               m_bad_reg;

    // Derived signals
    logic [CNT_W-1:0]   n_act;
    logic               bad_pos, more, trial, better, out_free, accept;
    logic [SLOT_W-1:0]  p_slot, p1_slot, idx_slot, rd_slot, wr_slot;
    logic [CITY_W-1:0]  city_rd, wr_city, dist_a, dist_b;
    logic               tour_rd_en, tour_wr_en, dist_rd_en, dist_oob;
    logic [DADDR_W-1:0] dist_raddr, dist_waddr;
    logic               dist_wr_ok;
    logic [LEN_W:0]     sum_wide;

    assign uc       = tsls_pkg::ucode(pc_reg);
    assign s_ready  = uc.in_ready;
    assign accept   = s_valid && uc.in_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign trial    = (req_reg == tsls_pkg::REQ_SWAP);

    // Clamp the active city count to 2..MAX_CITIES
    always_comb begin
        if (cfg_cc_reg < tsls_pkg::CC_W'(2)) begin
            n_act = CNT_W'(2);
        end else if (32'(cfg_cc_reg) > MAXC) begin
            n_act = CNT_W'(MAXC);
        end else begin
            n_act = CNT_W'(cfg_cc_reg);
        end
    end

    // Swap position checks and loop condition
    assign bad_pos  = 32'(pos_reg) > (32'(n_act) - 32'd2);
    assign more     = ({1'b0, idx_reg} + 1'b1) < {1'b0, n_act};
    assign better   = sum_reg < cur_len_reg;
    assign p_slot   = SLOT_W'(pos_reg);
    assign p1_slot  = p_slot + 1'b1;
    assign idx_slot = SLOT_W'(idx_reg);

    // Map the walk index onto a physical slot, exchanging p and p+1 on a trial
    always_comb begin
        if (uc.sum_start) begin
            rd_slot = (trial && p_slot == '0) ? p1_slot : '0;
        end else if (trial && idx_slot == p_slot) begin
            rd_slot = p1_slot;
        end else if (trial && idx_slot == p1_slot) begin
            rd_slot = p_slot;
        end else begin
            rd_slot = idx_slot;
        end
    end

    // Unwritten tour slots read as their own index
    assign city_rd    = tour_qv_reg ? tour_q_reg : CITY_W'(tour_qa_reg);
    assign tour_rd_en = uc.sum_start || uc.tour_rd;

    // Tour write port
    always_comb begin
        tour_wr_en = 1'b0;
        wr_slot    = p_slot;
        wr_city    = cid_reg;
        if (uc.wr_tour) begin
            tour_wr_en = 32'(pos_reg) < MAXC;
        end else if (uc.wr_a) begin
            tour_wr_en = 1'b1;
            wr_city    = swap_a_reg;
        end else if (uc.wr_b) begin
            tour_wr_en = 1'b1;
            wr_slot    = p1_slot;
            wr_city    = swap_b_reg;
        end
    end

    // Distance ports
    assign dist_a     = prev_reg;
    assign dist_b     = uc.close ? first_reg : city_rd;
    assign dist_rd_en = uc.link || uc.close;
    assign dist_oob   = (32'(dist_a) >= MAXC) || (32'(dist_b) >= MAXC);
    assign dist_raddr = DADDR_W'(dist_a) * DADDR_W'(MAXC) + DADDR_W'(dist_b);
    assign dist_wr_ok = (32'(from_reg) < MAXC) && (32'(to_reg) < MAXC);
    assign dist_waddr = DADDR_W'(from_reg) * DADDR_W'(MAXC) + DADDR_W'(to_reg);

    // Saturating accumulate of the distance read in the cycle before
    assign sum_wide = {1'b0, sum_reg} + (LEN_W + 1)'(doob_reg ? '0 : dist_q_reg);

    // Next program step
    always_comb begin
        case (uc.cond)
            tsls_pkg::COND_NEXT:     pc_next = pc_reg + 1'b1;
            tsls_pkg::COND_ALWAYS:   pc_next = uc.target;
            tsls_pkg::COND_WAIT_IN:  pc_next = s_valid ? uc.target : pc_reg;
            tsls_pkg::COND_DISPATCH: pc_next = tsls_pkg::dispatch(req_reg);
            tsls_pkg::COND_NOT_BAD:  pc_next = bad_pos ? pc_reg + 1'b1 : uc.target;
            tsls_pkg::COND_SCOUT:    pc_next = scout_reg ? uc.target : pc_reg + 1'b1;
            tsls_pkg::COND_MORE:     pc_next = more ? uc.target : pc_reg + 1'b1;
            tsls_pkg::COND_TRIAL:    pc_next = trial ? uc.target : pc_reg + 1'b1;
            tsls_pkg::COND_BETTER:   pc_next = better ? uc.target : pc_reg + 1'b1;
            tsls_pkg::COND_WAIT_OUT: pc_next = out_free ? uc.target : pc_reg;
            default:                 pc_next = tsls_pkg::STEP_FETCH;
        endcase
    end

    // Datapath next values
    always_comb begin
        cur_len_next = cur_len_reg;
        stall_next   = stall_reg;
        scout_next   = scout_reg;
        acc_next     = acc_reg;
        bad_next     = bad_reg;
        sum_next     = sum_reg;
        idx_next     = idx_reg;
        prev_next    = prev_reg;
        first_next   = first_reg;
        swap_a_next  = swap_a_reg;
        swap_b_next  = swap_b_reg;

        // accumulate whenever distance data has arrived
        if (dv_reg) begin
            sum_next = sum_wide[LEN_W] ? '1 : sum_wide[LEN_W-1:0];
        end
        if (accept) begin
            acc_next = 1'b0;
            bad_next = 1'b0;
        end
        if (uc.set_bad) begin
            bad_next = 1'b1;
        end
        if (uc.sum_start) begin
            sum_next = '0;
            idx_next = '0;
        end
        // capture the trial cities of slots p and p+1 for a later write-back
        if (uc.first || uc.link) begin
            prev_next = city_rd;
            if (idx_slot == p_slot) begin
                swap_a_next = city_rd;
            end
            if (idx_slot == p1_slot) begin
                swap_b_next = city_rd;
            end
        end
        if (uc.first) begin
            first_next = city_rd;
            idx_next   = CNT_W'(1);
        end
        if (uc.link) begin
            idx_next = idx_reg + 1'b1;
        end
        if (uc.eval_cmt) begin
            cur_len_next = sum_reg;
            stall_next   = '0;
            scout_next   = 1'b0;
        end
        if (uc.stall_upd) begin
            if (stall_reg >= cfg_limit_reg) begin
                scout_next = 1'b1;
            end else begin
                stall_next = stall_reg + 1'b1;
            end
        end
        if (uc.wr_a) begin
            cur_len_next = sum_reg;
            stall_next   = '0;
            acc_next     = 1'b1;
        end
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= tsls_pkg::STEP_FETCH;
            cfg_cc_reg    <= tsls_pkg::CITY_COUNT_RST;
            cfg_limit_reg <= tsls_pkg::STALL_LIMIT_RST;
            cur_len_reg   <= '1;
            stall_reg     <= '0;
            scout_reg     <= 1'b0;
            acc_reg       <= 1'b0;
            bad_reg       <= 1'b0;
            dv_reg        <= 1'b0;
            m_valid_reg   <= 1'b0;
            tour_vld_reg  <= '0;
        end else begin
            pc_reg      <= pc_next;
            cur_len_reg <= cur_len_next;
            stall_reg   <= stall_next;
            scout_reg   <= scout_next;
            acc_reg     <= acc_next;
            bad_reg     <= bad_next;
            dv_reg      <= dist_rd_en;
            if (cfg_we) begin
                case (cfg_addr)
                    tsls_pkg::CFG_CITY_COUNT:  cfg_cc_reg    <= cfg_wdata[tsls_pkg::CC_W-1:0];
                    tsls_pkg::CFG_STALL_LIMIT: cfg_limit_reg <= cfg_wdata[STALL_W-1:0];
                    default:                   cfg_cc_reg    <= cfg_cc_reg;
                endcase
            end
            if (tour_wr_en) begin
                tour_vld_reg[wr_slot] <= 1'b1;
            end
            // load the result, drop it once taken
            if (uc.out_ld && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        sum_reg    <= sum_next;
        idx_reg    <= idx_next;
        prev_reg   <= prev_next;
        first_reg  <= first_next;
        swap_a_reg <= swap_a_next;
        swap_b_reg <= swap_b_next;
        doob_reg   <= dist_oob;
        if (accept) begin
            req_reg  <= s_req_type;
            from_reg <= s_from_city;
            to_reg   <= s_to_city;
            dval_reg <= s_distance_value;
            pos_reg  <= s_position;
            cid_reg  <= s_city_id;
        end
        if (uc.out_ld && out_free) begin
            m_len_reg   <= cur_len_reg;
            m_acc_reg   <= acc_reg;
            m_stall_reg <= stall_reg;
            m_scout_reg <= scout_reg;
            m_bad_reg   <= bad_reg;
        end
    end

    // Tour store: one write and one registered read port
    always_ff @(posedge aclk) begin
        if (tour_wr_en) begin
            tour_mem[wr_slot] <= wr_city;
        end
        if (tour_rd_en) begin
            tour_q_reg  <= tour_mem[rd_slot];
            tour_qv_reg <= tour_vld_reg[rd_slot];
            tour_qa_reg <= rd_slot;
        end
    end

    // Distance store: one write and one registered read port
    always_ff @(posedge aclk) begin
        if (uc.wr_dist && dist_wr_ok) begin
            dist_mem[dist_waddr] <= DBITS'(dval_reg);
        end
        if (dist_rd_en) begin
            dist_q_reg <= dist_mem[dist_raddr];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_tour_length = m_len_reg;
    assign m_accepted    = m_acc_reg;
    assign m_stall_count = m_stall_reg;
    assign m_scout       = m_scout_reg;
    assign m_bad_request = m_bad_reg;

`ifndef SYNTHESIS
    // A kept swap never reports a bad position and always restarts the stall count
    a_accept_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_accepted |-> !m_bad_request && (m_stall_count == '0))
        else $error("kept swap with bad flag or nonzero stall count");

    // An accepted transaction is decoded in the following cycle
    a_fetch_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> pc_reg == tsls_pkg::STEP_DECODE)
        else $error("accepted transaction not decoded");

    // A new result only appears from the final program step
    a_out_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(pc_reg == tsls_pkg::STEP_DONE))
        else $error("result loaded outside the final step");
`endif

endmodule

FILE: tb/sv/tour_swap_local_search_tb.sv
// Self-checking testbench of the tour swap local search block.
module tour_swap_local_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REQ_W      = tsls_pkg::REQ_W;
    localparam int CITY_W     = tsls_pkg::CITY_W;
    localparam int DIN_W      = tsls_pkg::DIN_W;
    localparam int POS_W      = tsls_pkg::POS_W;
    localparam int LEN_W      = tsls_pkg::LEN_W;
    localparam int STALL_W    = tsls_pkg::STALL_W;
    localparam int CC_W       = tsls_pkg::CC_W;
    localparam int CFG_IDX_W  = tsls_pkg::CFG_IDX_W;
    localparam int CFG_DW     = tsls_pkg::CFG_DW;
    localparam int MAX_CITIES = tsls_pkg::MAX_CITIES;
    localparam int DIST_BITS  = tsls_pkg::DIST_BITS;

    localparam int POOL_N      = 10;    // cities allowed into the tour
    localparam int STUCK_LIMIT = 5000;  // the run ends when no handshake is seen for this long

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [CITY_W-1:0] from_city;
        logic [CITY_W-1:0] to_city;
        logic [DIN_W-1:0]  dist_val;
        logic [POS_W-1:0]  pos;
        logic [CITY_W-1:0] cid;
    } bee_req_t;

    typedef struct packed {
        logic [LEN_W-1:0]   tour_length;
        logic               accepted;
        logic [STALL_W-1:0] stall_count;
        logic               scout;
        logic               bad_request;
    } bee_res_t;

    typedef logic [MAX_CITIES-1:0][CITY_W-1:0] route_t;

    logic                 aclk;
    logic                 aresetn          = 1'b0;
    logic                 cfg_we           = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr         = '0;
    logic [CFG_DW-1:0]    cfg_wdata        = '0;
    logic                 s_valid          = 1'b0;
    logic                 s_ready;
    logic [REQ_W-1:0]     s_req_type       = '0;
    logic [CITY_W-1:0]    s_from_city      = '0;
    logic [CITY_W-1:0]    s_to_city        = '0;
    logic [DIN_W-1:0]     s_distance_value = '0;
    logic [POS_W-1:0]     s_position       = '0;
    logic [CITY_W-1:0]    s_city_id        = '0;
    logic                 m_valid;
    logic                 m_ready          = 1'b0;
    logic [LEN_W-1:0]     m_tour_length;
    logic                 m_accepted;
    logic [STALL_W-1:0]   m_stall_count;
    logic                 m_scout;
    logic                 m_bad_request;

    // Shadow state of the bee
    logic [DIST_BITS-1:0] dist_mem [0:MAX_CITIES*MAX_CITIES-1];
    route_t               route_now;
    logic [LEN_W-1:0]     length_now;
    logic [STALL_W-1:0]   stall_now;
    logic                 scout_now;
    logic [CC_W-1:0]      city_count_now;
    logic [STALL_W-1:0]   stall_limit_now;

    bee_req_t          request_q [$];
    bee_res_t          due_status_q [$];
    bee_req_t          next_req;
    bee_res_t          want_res;
    logic [CITY_W-1:0] pool [0:POOL_N-1];
    bit                req_taken = 1'b0;
    bit                steady    = 1'b0;
    int                fail_count = 0;
    int                stuck_cycles = 0;
    int                slot_i;

    tour_swap_local_search i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_from_city      (s_from_city),
        .s_to_city        (s_to_city),
        .s_distance_value (s_distance_value),
        .s_position       (s_position),
        .s_city_id        (s_city_id),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_tour_length    (m_tour_length),
        .m_accepted       (m_accepted),
        .m_stall_count    (m_stall_count),
        .m_scout          (m_scout),
        .m_bad_request    (m_bad_request)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Clamp the city count register to the usable range
    function automatic int active_cities(input logic [CC_W-1:0] cc);
        if (cc < 2) return 2;
        if (cc > MAX_CITIES) return MAX_CITIES;
        return int'(cc);
    endfunction

    // Closed tour length over the first n slots, saturating at all ones
    function automatic logic [LEN_W-1:0] closed_length(input route_t rt, input int n);
        logic [LEN_W:0]    acc;
        logic [CITY_W-1:0] nxt;
        acc = '0;
        for (int i = 0; i < n; i++) begin
            nxt = (i + 1 < n) ? rt[i + 1] : rt[0];
            acc = acc + dist_mem[{rt[i], nxt}];
            if (acc > {1'b0, {LEN_W{1'b1}}}) acc = {1'b0, {LEN_W{1'b1}}};
        end
        return acc[LEN_W-1:0];
    endfunction

    // Apply the transaction on the request ports to the shadow state, queue its status
    task automatic step_bee_search();
        route_t           trial;
        logic [LEN_W-1:0] trial_len;
        bee_res_t         res;
        int               n;
        int               p;
        n = active_cities(city_count_now);
        p = int'(s_position);
        res = '0;
        case (s_req_type)
            tsls_pkg::REQ_LOAD_DIST: dist_mem[{s_from_city, s_to_city}] = s_distance_value;
            tsls_pkg::REQ_LOAD_TOUR: route_now[p] = s_city_id;
            tsls_pkg::REQ_EVAL: begin
                length_now = closed_length(route_now, n);
                stall_now  = '0;
                scout_now  = 1'b0;
            end
            tsls_pkg::REQ_SWAP: begin
                if (p > n - 2) begin
                    res.bad_request = 1'b1;
                end else if (!scout_now) begin
                    trial        = route_now;
                    trial[p]     = route_now[p + 1];
                    trial[p + 1] = route_now[p];
                    trial_len    = closed_length(trial, n);
                    if (trial_len < length_now) begin
                        route_now    = trial;
                        length_now   = trial_len;
                        stall_now    = '0;
                        res.accepted = 1'b1;
                    end else if (stall_now >= stall_limit_now) begin
                        scout_now = 1'b1;
                    end else begin
                        stall_now = stall_now + 1'b1;
                    end
                end
            end
            default: ;
        endcase
        res.tour_length = length_now;
        res.stall_count = stall_now;
        res.scout       = scout_now;
        due_status_q = {due_status_q, res};
    endtask

    function automatic void check_field(input string name, input logic [LEN_W-1:0] want,
                                        input logic [LEN_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Sample both channels and the register port, predict and compare
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (slot_i = 0; slot_i < MAX_CITIES; slot_i++) begin
                route_now[slot_i] = CITY_W'(slot_i);
            end
            length_now      = '1;
            stall_now       = '0;
            scout_now       = 1'b0;
            city_count_now  = tsls_pkg::CITY_COUNT_RST;
            stall_limit_now = tsls_pkg::STALL_LIMIT_RST;
            stuck_cycles    = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    tsls_pkg::CFG_CITY_COUNT:  city_count_now  = cfg_wdata[CC_W-1:0];
                    tsls_pkg::CFG_STALL_LIMIT: stall_limit_now = cfg_wdata[STALL_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (due_status_q.size() == 0) begin
                    $error("result transaction with no prediction pending");
                    fail_count++;
                end else begin
                    want_res = due_status_q.pop_front();
                    check_field("tour_length", want_res.tour_length, m_tour_length);
                    check_field("accepted", LEN_W'(want_res.accepted), LEN_W'(m_accepted));
                    check_field("stall_count", LEN_W'(want_res.stall_count),
                                LEN_W'(m_stall_count));
                    check_field("scout", LEN_W'(want_res.scout), LEN_W'(m_scout));
                    check_field("bad_request", LEN_W'(want_res.bad_request),
                                LEN_W'(m_bad_request));
                end
            end
            if (s_valid && s_ready) begin
                step_bee_search();
                req_taken = 1'b1;
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) stuck_cycles = 0;
            else stuck_cycles++;
        end
    end

    // Drive requests and result backpressure on the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            m_ready   <= 1'b0;
            req_taken = 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= 7);
            if (!s_valid || req_taken) begin
                req_taken = 1'b0;
                if (request_q.size() != 0 && (steady || $urandom_range(99) >= 7)) begin
                    next_req = request_q.pop_front();
                    s_req_type       <= next_req.req;
                    s_from_city      <= next_req.from_city;
                    s_to_city        <= next_req.to_city;
                    s_distance_value <= next_req.dist_val;
                    s_position       <= next_req.pos;
                    s_city_id        <= next_req.cid;
                    s_valid          <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // End the run when the block stops moving
    initial begin
        while (stuck_cycles < STUCK_LIMIT) @(posedge aclk);
        $display("simulation failed");
        $finish;
    end

    // Random fields everywhere, distances biased toward the extremes
    function automatic bee_req_t noise_req(input logic [REQ_W-1:0] kind);
        bee_req_t r;
        int       roll;
        r.req       = kind;
        r.from_city = CITY_W'($urandom);
        r.to_city   = CITY_W'($urandom);
        r.pos       = POS_W'($urandom);
        r.cid       = CITY_W'($urandom);
        roll        = $urandom_range(7);
        r.dist_val  = (roll == 0) ? '0 : (roll == 1) ? '1 : DIN_W'($urandom);
        return r;
    endfunction

    function automatic logic [CITY_W-1:0] pick_city();
        return pool[$urandom_range(POOL_N - 1)];
    endfunction

    function automatic void queue_item(input logic [REQ_W-1:0] kind,
                                       input logic [POS_W-1:0] pos,
                                       input logic [CITY_W-1:0] cid);
        bee_req_t r;
        r     = noise_req(kind);
        r.pos = pos;
        r.cid = cid;
        request_q = {request_q, r};
    endfunction

    // Hold until every request is taken and every status has come back
    task automatic drain();
        while (request_q.size() != 0 || s_valid || due_status_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // One search phase: evaluate, then mostly swaps mixed with reloads
    task automatic random_phase(input logic [CFG_DW-1:0] cc_word,
                                input logic [CFG_DW-1:0] limit_word,
                                input int count, input bit calm);
        bee_req_t r;
        int       n;
        int       roll;
        drain();
        write_reg(tsls_pkg::CFG_CITY_COUNT, cc_word);
        write_reg(tsls_pkg::CFG_STALL_LIMIT, limit_word);
        n = active_cities(cc_word[CC_W-1:0]);
        steady = calm;
        @(posedge aclk);
        request_q = {request_q, noise_req(tsls_pkg::REQ_EVAL)};
        for (int k = 1; k < count; k++) begin
            roll = $urandom_range(99);
            if (roll < 10) begin
                r = noise_req(tsls_pkg::REQ_EVAL);
            end else if (roll < 78) begin
                r = noise_req(tsls_pkg::REQ_SWAP);
                if ($urandom_range(9) == 0) r.pos = POS_W'($urandom_range(127, n - 1));
                else r.pos = POS_W'($urandom_range(n - 2, 0));
            end else if (roll < 89) begin
                r = noise_req(tsls_pkg::REQ_LOAD_DIST);
                if ($urandom_range(3) != 0) begin
                    r.from_city = pick_city();
                    r.to_city   = pick_city();
                end
            end else begin
                r = noise_req(tsls_pkg::REQ_LOAD_TOUR);
                r.cid = pick_city();
            end
            request_q = {request_q, r};
        end
    endtask

    initial begin
        bee_req_t          r;
        logic [CITY_W-1:0] cand;
        bit                dup;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Tour cities come from a small pool whose distances are all loaded
        pool[0] = '0;
        pool[1] = '1;
        for (int k = 2; k < POOL_N; k++) begin
            do begin
                cand = CITY_W'($urandom_range(126, 1));
                dup  = 1'b0;
                for (int j = 0; j < k; j++) if (pool[j] == cand) dup = 1'b1;
            end while (dup);
            pool[k] = cand;
        end
        @(posedge aclk);

        // Fill the distance table for the pool and every tour slot
        for (int j = 0; j < POOL_N; j++) begin
            for (int k = 0; k < POOL_N; k++) begin
                r = noise_req(tsls_pkg::REQ_LOAD_DIST);
                r.from_city = pool[j];
                r.to_city   = pool[k];
                request_q = {request_q, r};
            end
        end
        for (int k = 0; k < MAX_CITIES; k++) begin
            queue_item(tsls_pkg::REQ_LOAD_TOUR, POS_W'(k), pick_city());
        end

        // Directed: swap before any evaluate, edge slots, distance extremes
        queue_item(tsls_pkg::REQ_SWAP, 7'd0, '0);
        queue_item(tsls_pkg::REQ_EVAL, '0, '0);
        queue_item(tsls_pkg::REQ_SWAP, 7'd126, '0);
        queue_item(tsls_pkg::REQ_SWAP, 7'd127, '0);
        queue_item(tsls_pkg::REQ_SWAP, 7'd63, '0);
        queue_item(tsls_pkg::REQ_EVAL, '0, '0);
        queue_item(tsls_pkg::REQ_LOAD_TOUR, 7'd0, 7'd127);
        queue_item(tsls_pkg::REQ_LOAD_TOUR, 7'd127, 7'd0);
        r = noise_req(tsls_pkg::REQ_LOAD_DIST);
        r.from_city = 7'd127;
        r.to_city   = 7'd0;
        r.dist_val  = '1;
        request_q = {request_q, r};
        r = noise_req(tsls_pkg::REQ_LOAD_DIST);
        r.from_city = 7'd0;
        r.to_city   = 7'd0;
        r.dist_val  = '0;
        request_q = {request_q, r};
        queue_item(tsls_pkg::REQ_EVAL, '0, '0);
        queue_item(tsls_pkg::REQ_SWAP, 7'd1, '0);

        // Directed: count below range, zero stall limit, scout blocking and clearing
        drain();
        write_reg(tsls_pkg::CFG_CITY_COUNT, 16'd0);
        write_reg(tsls_pkg::CFG_STALL_LIMIT, 16'd0);
        @(posedge aclk);
        queue_item(tsls_pkg::REQ_EVAL, '0, '0);
        queue_item(tsls_pkg::REQ_SWAP, 7'd0, '0);
        queue_item(tsls_pkg::REQ_SWAP, 7'd0, '0);
        queue_item(tsls_pkg::REQ_SWAP, 7'd1, '0);
        queue_item(tsls_pkg::REQ_EVAL, '0, '0);
        queue_item(tsls_pkg::REQ_SWAP, 7'd0, '0);

        random_phase(16'd2, 16'd0, 150, 1'b0);
        random_phase(16'd3, 16'd1, 150, 1'b0);
        random_phase(16'h0105, 16'd3, 150, 1'b0);
        random_phase(16'd1, 16'd2, 120, 1'b0);
        random_phase(CFG_DW'($urandom_range(24, 6)), CFG_DW'($urandom_range(12, 0)), 120, 1'b1);
        random_phase(16'd255, 16'hFFFF, 120, 1'b0);
        random_phase(CFG_DW'($urandom_range(16, 4)), CFG_DW'($urandom_range(8, 0)), 120, 1'b0);
        random_phase(CFG_DW'($urandom_range(40, 2)), CFG_DW'($urandom_range(30, 0)), 120, 1'b0);
        random_phase(16'd128, 16'd20, 60, 1'b0);
        random_phase(CFG_DW'($urandom_range(10, 2)), 16'd4, 150, 1'b0);

        drain();
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/tsls_pkg.sv
sv/tour_swap_local_search.sv
tb/sv/tour_swap_local_search_tb.sv
